@@ sv/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// shared geometry, widths, character codes and types of the text console
// ----------------------------------------------------------------------------
package tcw_pkg;

   // screen geometry
   localparam int COLUMNS     = 80;
   localparam int ROWS        = 25;
   localparam int CELL_COUNT  = COLUMNS * ROWS;
   localparam int SHIFT_CELLS = COLUMNS * (ROWS - 1);

   // widths
   localparam int COL_W       = $clog2(COLUMNS);
   localparam int ROW_W       = $clog2(ROWS);
   localparam int ADDR_W      = $clog2(CELL_COUNT);
   localparam int CNT_W       = $clog2(CELL_COUNT + 1);
   localparam int ATTR_W      = 8;
   localparam int CHAR_W      = 8;
   localparam int CELL_W      = ATTR_W + CHAR_W;
   localparam int OP_W        = 2;
   localparam int READ_ADDR_W = 11;
   localparam int CURSOR_W    = 11;

   // constants
   localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0f;
   localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0a;
   localparam int                TAB_STEP     = 4;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      ST_FILL,
      ST_IDLE,
      ST_SCROLL,
      ST_FINISH
   } state_type;

   // one cycle of requests to the cell memory
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CELL_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_req_type;

endpackage

@@ sv/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer
// text console engine: cell buffer, cursor, put / read / clear operations
// ----------------------------------------------------------------------------
// flow: put and read go from accept to the FINISH state, which loads the
//   result register once the result side is free; only then is a new item
//   taken; clear writes blank cells (one blank write a cycle); a put that
//   scrolls moves the cells up a row (one cell moved a cycle, set by the
//   single write port of the cell memory), then blanks the last row
// reset: synchronous; after reset a clearing pass writes blank cell 0x0f20
//   to all 2000 cells before the first item is taken; csr writes are taken throughout
// ----------------------------------------------------------------------------
module text_console_writer (
   input  logic        clock,
   input  logic        reset,

   // input beats
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] char_code, [18:8] read_address, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] op

   // result beats
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [10:0] cursor_pos, [26:11] read_cell, rest zero

   // attribute register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   localparam int CW1 = tcw_pkg::COL_W + 1;
   localparam int RW1 = tcw_pkg::ROW_W + 1;

   // input fields
   logic [tcw_pkg::OP_W-1:0]        req_op;
   logic [tcw_pkg::CHAR_W-1:0]      req_char;
   logic [tcw_pkg::READ_ADDR_W-1:0] req_addr;

   assign req_op   = req_tuser;
   assign req_char = req_tdata[7:0];
   assign req_addr = req_tdata[18:8];

   // registers
   tcw_pkg::state_type             state_ff, state_in;
   logic [tcw_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic [tcw_pkg::COL_W-1:0]      col_ff, col_in;
   logic [tcw_pkg::ROW_W-1:0]      row_ff, row_in;
   logic [tcw_pkg::ATTR_W-1:0]     attr_ff, attr_in;
   logic [tcw_pkg::ATTR_W-1:0]     fill_attr_ff, fill_attr_in;
   logic                           fill_init_ff, fill_init_in;
   logic                           wr_pend_ff, wr_pend_in;
   logic [tcw_pkg::ADDR_W-1:0]     wr_addr_ff, wr_addr_in;
   logic                           rd_hit_ff, rd_hit_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [31:0]                    rsp_data_ff, rsp_data_in;

   // memory
   tcw_pkg::ram_req_type           ram_req;
   logic [tcw_pkg::CELL_W-1:0]     ram_rd_data;

   tcw_cell_ram u_cell_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rd_data)
   );

   // handshakes
   logic req_fire;
   logic rsp_load;
   logic fill_done;
   logic scroll_done;
   logic read_in_range;

   assign req_tready    = (state_ff == tcw_pkg::ST_IDLE);
   assign req_fire      = req_tvalid & req_tready;
   assign csr_ready     = 1'b1;
   assign rsp_load      = (state_ff == tcw_pkg::ST_FINISH) & (~rsp_valid_ff | rsp_tready);
   assign fill_done     = (cnt_ff == tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT - 1));
   assign scroll_done   = (cnt_ff == tcw_pkg::CNT_W'(tcw_pkg::SHIFT_CELLS));
   assign read_in_range = ({1'b0, req_addr} < (tcw_pkg::READ_ADDR_W + 1)'(tcw_pkg::CELL_COUNT));

   // cursor cell address, also the reported position
   logic [tcw_pkg::ADDR_W-1:0] base_addr;
   assign base_addr = tcw_pkg::ADDR_W'(tcw_pkg::ADDR_W'(row_ff) *
                                       tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS))
                    + tcw_pkg::ADDR_W'(col_ff);

   // put decode: new cursor and the one cell write it may cause
   logic [CW1-1:0]                 col_wide;
   logic [CW1-1:0]                 tab_col;
   logic [CW1-1:0]                 nx_col;
   logic [RW1-1:0]                 nx_row;
   logic                           put_wr;
   logic [tcw_pkg::ADDR_W-1:0]     put_addr;
   logic [tcw_pkg::CHAR_W-1:0]     put_char;
   logic                           put_scroll;

   always_comb begin
      col_wide = {1'b0, col_ff};
      tab_col  = (col_wide + CW1'(tcw_pkg::TAB_STEP)) & ~CW1'(tcw_pkg::TAB_STEP - 1);
      nx_col   = col_wide;
      nx_row   = {1'b0, row_ff};
      put_wr   = 1'b0;
      put_addr = base_addr;
      put_char = req_char;
      case (req_char)
         tcw_pkg::CH_NEWLINE: begin
            nx_col = '0;
            nx_row = {1'b0, row_ff} + RW1'(1);
         end
         tcw_pkg::CH_BACKSPACE: begin
            // at column 0 nothing happens
            if (col_ff != '0) begin
               nx_col   = col_wide - CW1'(1);
               put_wr   = 1'b1;
               put_addr = base_addr - tcw_pkg::ADDR_W'(1);
               put_char = tcw_pkg::BLANK_CHAR;
            end
         end
         tcw_pkg::CH_TAB: begin
            nx_col = tab_col;
            if (tab_col >= CW1'(tcw_pkg::COLUMNS)) begin
               nx_col = '0;
               nx_row = {1'b0, row_ff} + RW1'(1);
            end
         end
         default: begin
            put_wr = 1'b1;
            nx_col = col_wide + CW1'(1);
            if (nx_col >= CW1'(tcw_pkg::COLUMNS)) begin
               nx_col = '0;
               nx_row = {1'b0, row_ff} + RW1'(1);
            end
         end
      endcase
      put_scroll = (nx_row >= RW1'(tcw_pkg::ROWS));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcw_pkg::ST_FILL: begin
            if (fill_done) begin
               state_in = fill_init_ff ? tcw_pkg::ST_IDLE : tcw_pkg::ST_FINISH;
            end
         end
         tcw_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_op == tcw_pkg::OP_PUT && put_scroll) begin
                  state_in = tcw_pkg::ST_SCROLL;
               end else if (req_op == tcw_pkg::OP_CLEAR) begin
                  state_in = tcw_pkg::ST_FILL;
               end else begin
                  state_in = tcw_pkg::ST_FINISH;
               end
            end
         end
         tcw_pkg::ST_SCROLL: begin
            if (scroll_done) begin
               state_in = tcw_pkg::ST_FILL;
            end
         end
         tcw_pkg::ST_FINISH: begin
            if (rsp_load) begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcw_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      ram_req      = '0;
      cnt_in       = cnt_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      fill_attr_in = fill_attr_ff;
      fill_init_in = fill_init_ff;
      wr_pend_in   = wr_pend_ff;
      wr_addr_in   = wr_addr_ff;
      rd_hit_in    = rd_hit_ff;
      case (state_ff)
         tcw_pkg::ST_FILL: begin
            // blank sweep from the counter up to the last cell
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = cnt_ff[tcw_pkg::ADDR_W-1:0];
            ram_req.wr_data = {fill_attr_ff, tcw_pkg::BLANK_CHAR};
            cnt_in          = cnt_ff + tcw_pkg::CNT_W'(1);
            if (fill_done) begin
               fill_init_in = 1'b0;
            end
         end
         tcw_pkg::ST_IDLE: begin
            if (req_fire) begin
               rd_hit_in = 1'b0;
               case (req_op)
                  tcw_pkg::OP_PUT: begin
                     ram_req.wr_en   = put_wr;
                     ram_req.wr_addr = put_addr;
                     ram_req.wr_data = {attr_ff, put_char};
                     col_in          = nx_col[tcw_pkg::COL_W-1:0];
                     if (put_scroll) begin
                        // cursor stays on the last row
                        row_in     = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
                        cnt_in     = '0;
                        wr_pend_in = 1'b0;
                     end else begin
                        row_in = nx_row[tcw_pkg::ROW_W-1:0];
                     end
                  end
                  tcw_pkg::OP_READ: begin
                     rd_hit_in       = read_in_range;
                     ram_req.rd_en   = read_in_range;
                     ram_req.rd_addr = tcw_pkg::ADDR_W'(req_addr);
                  end
                  tcw_pkg::OP_CLEAR: begin
                     cnt_in       = '0;
                     fill_attr_in = attr_ff;
                     col_in       = '0;
                     row_in       = '0;
                  end
                  default: begin
                     rd_hit_in = 1'b0;
                  end
               endcase
            end
         end
         tcw_pkg::ST_SCROLL: begin
            // read one row ahead, write back the cell read in the last cycle
            if (wr_pend_ff) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = wr_addr_ff;
               ram_req.wr_data = ram_rd_data;
            end
            if (!scroll_done) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = tcw_pkg::ADDR_W'(cnt_ff + tcw_pkg::CNT_W'(tcw_pkg::COLUMNS));
               wr_addr_in      = cnt_ff[tcw_pkg::ADDR_W-1:0];
               wr_pend_in      = 1'b1;
               cnt_in          = cnt_ff + tcw_pkg::CNT_W'(1);
            end else begin
               // counter already points at the last row for the blank sweep
               wr_pend_in   = 1'b0;
               fill_attr_in = attr_ff;
            end
         end
         tcw_pkg::ST_FINISH: begin
            rd_hit_in = rd_hit_ff;
         end
         default: begin
            ram_req = '0;
         end
      endcase
   end

   // result register
   logic [tcw_pkg::CELL_W-1:0] read_cell;
   assign read_cell = rd_hit_ff ? ram_rd_data : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {5'd0, read_cell, tcw_pkg::CURSOR_W'(base_addr)};
      end
   end

   // attribute register
   always_comb begin
      attr_in = attr_ff;
      if (csr_valid && csr_ready) begin
         attr_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcw_pkg::ST_FILL;
         cnt_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         attr_ff      <= tcw_pkg::RESET_ATTR;
         fill_attr_ff <= tcw_pkg::RESET_ATTR;
         fill_init_ff <= 1'b1;
         wr_pend_ff   <= 1'b0;
         rd_hit_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         attr_ff      <= attr_in;
         fill_attr_ff <= fill_attr_in;
         fill_init_ff <= fill_init_in;
         wr_pend_ff   <= wr_pend_in;
         rd_hit_ff    <= rd_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff  <= wr_addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ sv/tcw_cell_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_cell_ram
// screen cell store: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module tcw_cell_ram (
   input  logic                         clock,
   input  tcw_pkg::ram_req_type         ram_req,
   output logic [tcw_pkg::CELL_W-1:0]   rd_data
);

   logic [tcw_pkg::CELL_W-1:0] cells [tcw_pkg::CELL_COUNT];

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         cells[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data <= cells[ram_req.rd_addr];
      end
   end

endmodule

@@ sim/tcw_checker.sv @@
// ----------------------------------------------------------------------------
// tcw_checker
// watches the console's input, result and attribute channels, keeps its own
// model of cursor, cell buffer and attribute, and matches every result beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_checker (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] char_code, [18:8] read_address, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] op

   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [10:0] cursor_pos, [26:11] read_cell, rest zero

   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_data,

   output int          outstanding,
   output int          fail_count
);

   localparam int MAX_REPORTS = 10;
   localparam int RSP_USED    = tcw_pkg::CURSOR_W + tcw_pkg::CELL_W;

   typedef struct packed {
      logic [tcw_pkg::CURSOR_W-1:0] cursor_pos;
      logic [tcw_pkg::CELL_W-1:0]   read_cell;
   } console_rsp_type;

   logic [tcw_pkg::ATTR_W-1:0] text_attr;
   int unsigned                cur_col;
   int unsigned                cur_row;
   logic [tcw_pkg::CELL_W-1:0] screen [tcw_pkg::CELL_COUNT];
   console_rsp_type            pending_rsp_q [$];
   int                         rsp_seen;
   int                         errors;

   function automatic void blank_cells(int unsigned from, int unsigned upto);
      for (int unsigned i = from; i < upto; i++) begin
         screen[i] = {text_attr, tcw_pkg::BLANK_CHAR};
      end
   endfunction

   function automatic void line_feed();
      cur_col = 0;
      cur_row++;
   endfunction

   function automatic void put_char(logic [tcw_pkg::CHAR_W-1:0] ch);
      if (ch == tcw_pkg::CH_NEWLINE) begin
         line_feed();
      end else if (ch == tcw_pkg::CH_BACKSPACE) begin
         // stays put at the left margin
         if (cur_col > 0) begin
            cur_col--;
            screen[cur_row * tcw_pkg::COLUMNS + cur_col] = {text_attr, tcw_pkg::BLANK_CHAR};
         end
      end else if (ch == tcw_pkg::CH_TAB) begin
         cur_col = (cur_col + tcw_pkg::TAB_STEP) & ~(tcw_pkg::TAB_STEP - 1);
         if (cur_col >= tcw_pkg::COLUMNS) begin
            line_feed();
         end
      end else begin
         screen[cur_row * tcw_pkg::COLUMNS + cur_col] = {text_attr, ch};
         cur_col++;
         if (cur_col >= tcw_pkg::COLUMNS) begin
            line_feed();
         end
      end
      // past the bottom: move everything up a row, blank the last one
      if (cur_row >= tcw_pkg::ROWS) begin
         for (int unsigned i = 0; i < tcw_pkg::SHIFT_CELLS; i++) begin
            screen[i] = screen[i + tcw_pkg::COLUMNS];
         end
         blank_cells(tcw_pkg::SHIFT_CELLS, tcw_pkg::CELL_COUNT);
         cur_row = tcw_pkg::ROWS - 1;
      end
   endfunction

   task automatic advance_console(input logic [tcw_pkg::OP_W-1:0]        op,
                                  input logic [tcw_pkg::CHAR_W-1:0]      ch,
                                  input logic [tcw_pkg::READ_ADDR_W-1:0] addr,
                                  output console_rsp_type                rsp);
      logic [tcw_pkg::CELL_W-1:0] cell_value;
      cell_value = '0;
      case (op)
         tcw_pkg::OP_PUT: begin
            put_char(ch);
         end
         tcw_pkg::OP_READ: begin
            if (addr < tcw_pkg::CELL_COUNT) begin
               cell_value = screen[addr];
            end
         end
         tcw_pkg::OP_CLEAR: begin
            blank_cells(0, tcw_pkg::CELL_COUNT);
            cur_col = 0;
            cur_row = 0;
         end
         default: begin
            // spare op code leaves everything alone
         end
      endcase
      rsp.cursor_pos = tcw_pkg::CURSOR_W'(cur_row * tcw_pkg::COLUMNS + cur_col);
      rsp.read_cell  = cell_value;
   endtask

   always @(posedge clock) begin : watch_channels
      console_rsp_type          want;
      console_rsp_type          got;
      logic [31-RSP_USED:0]     pad;
      if (reset) begin
         text_attr = tcw_pkg::RESET_ATTR;
         cur_col   = 0;
         cur_row   = 0;
         blank_cells(0, tcw_pkg::CELL_COUNT);
         pending_rsp_q.delete();
         rsp_seen  = 0;
         errors    = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            text_attr = csr_data;
         end
         // results first, a beat accepted now cannot answer itself
         if (rsp_tvalid && rsp_tready) begin
            got.cursor_pos = rsp_tdata[tcw_pkg::CURSOR_W-1:0];
            got.read_cell  = rsp_tdata[tcw_pkg::CURSOR_W +: tcw_pkg::CELL_W];
            pad            = rsp_tdata[31:RSP_USED];
            if (pending_rsp_q.size() == 0) begin
               if (errors < MAX_REPORTS) begin
                  $display("result %0d with nothing expected: cursor_pos %0d read_cell %h",
                           rsp_seen, got.cursor_pos, got.read_cell);
               end
               errors++;
            end else begin
               want = pending_rsp_q.pop_front();
               if (got.cursor_pos !== want.cursor_pos || got.read_cell !== want.read_cell
                   || pad !== '0) begin
                  if (errors < MAX_REPORTS) begin
                     $display("result %0d: cursor exp %0d got %0d, cell exp %h got %h, pad %h",
                              rsp_seen, want.cursor_pos, got.cursor_pos,
                              want.read_cell, got.read_cell, pad);
                  end
                  errors++;
               end
            end
            rsp_seen++;
         end
         if (req_tvalid && req_tready) begin
            advance_console(req_tuser, req_tdata[7:0], req_tdata[18:8], want);
            pending_rsp_q.push_back(want);
         end
      end
      outstanding <= pending_rsp_q.size();
      fail_count  <= errors;
   end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// regression for the text console: directed corner beats, then phases of
// random text bursts under several attribute settings, with random gaps and
// stalls on both sides; results are matched by the checker beside the block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int     RESET_CYCLES   = 11;
   localparam int     MAX_GAP        = 17;
   localparam int     PHASES         = 5;
   localparam int     PHASE_ITEMS    = 100;
   // sender runs without gaps for this stretch of items
   localparam int     SEND_CALM_LO   = 220;
   localparam int     SEND_CALM_HI   = 280;
   // receiver takes beats back to back for this stretch, holds off once
   localparam int     TAKE_CALM_LO   = 320;
   localparam int     TAKE_CALM_HI   = 400;
   localparam int     HOLD_AT_BEAT   = 150;
   localparam int     HOLD_CYCLES    = 400;
   localparam int     DRAIN_CYCLES   = 100;
   // every item scrolling plus worst gaps, plus the clearing pass, several times
   localparam longint CYCLE_LIMIT    = 5_000_000;
   localparam logic [tcw_pkg::OP_W-1:0]        OP_SPARE      = 2'd3;
   localparam logic [tcw_pkg::READ_ADDR_W-1:0] READ_ADDR_TOP = '1;

   typedef enum int {
      BURST_LINE,
      BURST_TABS,
      BURST_NEWLINES,
      BURST_BACKSPACES,
      BURST_READS,
      BURST_CLEAR,
      BURST_NOISE
   } burst_kind_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // [7:0] char_code, [18:8] read_address, rest zero
   logic [1:0]  req_tuser  = '0;   // [1:0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [10:0] cursor_pos, [26:11] read_cell, rest zero
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data   = '0;

   int          outstanding;
   int          fail_count;
   int          items_sent = 0;
   longint      cycle_count = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   text_console_writer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   tcw_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   // watchdog, in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // result side: random stalls per beat, one long hold-off so the block
   // backs up into its input, and a stretch taken back to back
   initial begin : result_side
      int stall;
      int beats;
      beats = 0;
      forever begin
         if (beats == HOLD_AT_BEAT) begin
            stall = HOLD_CYCLES;
         end else if (beats >= TAKE_CALM_LO && beats < TAKE_CALM_HI) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, MAX_GAP);
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         beats++;
      end
   end

   // one input beat; valid stays up afterwards so back-to-back beats need
   // no second assignment in the same step
   task automatic send_item(input logic [tcw_pkg::OP_W-1:0]        op,
                            input logic [tcw_pkg::CHAR_W-1:0]      ch,
                            input logic [tcw_pkg::READ_ADDR_W-1:0] addr);
      int gap;
      if (items_sent >= SEND_CALM_LO && items_sent < SEND_CALM_HI) begin
         gap = 0;
      end else begin
         gap = $urandom_range(0, MAX_GAP);
      end
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {5'd0, addr, ch};
      do @(posedge clock); while (!(req_tvalid && req_tready));
      items_sent++;
   endtask

   // the unused fields get random filler
   task automatic put_byte(input logic [tcw_pkg::CHAR_W-1:0] ch);
      send_item(tcw_pkg::OP_PUT, ch,
                tcw_pkg::READ_ADDR_W'($urandom_range(0, READ_ADDR_TOP)));
   endtask

   task automatic read_at(input logic [tcw_pkg::READ_ADDR_W-1:0] addr);
      send_item(tcw_pkg::OP_READ, tcw_pkg::CHAR_W'($urandom_range(0, 255)), addr);
   endtask

   // drop valid and hold until every result is back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_attribute(input logic [tcw_pkg::ATTR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // one well-formed burst of console traffic
   task automatic run_burst(input burst_kind_type kind);
      int count;
      case (kind)
         BURST_LINE: begin
            // mostly printable text, some raw bytes; long ones wrap
            count = $urandom_range(1, 100);
            repeat (count) begin
               if ($urandom_range(0, 3) != 0) begin
                  put_byte(tcw_pkg::CHAR_W'($urandom_range(8'h20, 8'h7e)));
               end else begin
                  put_byte(tcw_pkg::CHAR_W'($urandom_range(0, 255)));
               end
            end
            if ($urandom_range(0, 9) < 7) begin
               put_byte(tcw_pkg::CH_NEWLINE);
            end
         end
         BURST_TABS: begin
            count = $urandom_range(1, 22);
            repeat (count) put_byte(tcw_pkg::CH_TAB);
         end
         BURST_NEWLINES: begin
            // now and then a full screen's worth, forcing scrolls
            count = ($urandom_range(0, 7) == 0) ? tcw_pkg::ROWS + 1 : $urandom_range(1, 4);
            repeat (count) put_byte(tcw_pkg::CH_NEWLINE);
         end
         BURST_BACKSPACES: begin
            count = $urandom_range(1, 12);
            repeat (count) put_byte(tcw_pkg::CH_BACKSPACE);
         end
         BURST_READS: begin
            count = $urandom_range(1, 8);
            repeat (count) begin
               if ($urandom_range(0, 4) != 0) begin
                  read_at(tcw_pkg::READ_ADDR_W'(
                             $urandom_range(0, tcw_pkg::CELL_COUNT - 1)));
               end else begin
                  read_at(tcw_pkg::READ_ADDR_W'(
                             $urandom_range(tcw_pkg::CELL_COUNT, READ_ADDR_TOP)));
               end
            end
         end
         BURST_CLEAR: begin
            send_item(tcw_pkg::OP_CLEAR, tcw_pkg::CHAR_W'($urandom_range(0, 255)),
                      tcw_pkg::READ_ADDR_W'($urandom_range(0, READ_ADDR_TOP)));
         end
         default: begin
            // noise: any op including the spare one, any field values
            count = $urandom_range(1, 4);
            repeat (count) begin
               send_item(tcw_pkg::OP_W'($urandom_range(0, 3)),
                         tcw_pkg::CHAR_W'($urandom_range(0, 255)),
                         tcw_pkg::READ_ADDR_W'($urandom_range(0, READ_ADDR_TOP)));
            end
         end
      endcase
   endtask

   function automatic burst_kind_type pick_burst();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return BURST_LINE;
      if (roll < 52) return BURST_TABS;
      if (roll < 64) return BURST_NEWLINES;
      if (roll < 72) return BURST_BACKSPACES;
      if (roll < 90) return BURST_READS;
      if (roll < 93) return BURST_CLEAR;
      return BURST_NOISE;
   endfunction

   initial begin : stimulus
      logic [tcw_pkg::ATTR_W-1:0] attr_plan [PHASES];
      attr_plan[0] = 8'h00;
      attr_plan[1] = 8'hff;
      attr_plan[2] = tcw_pkg::ATTR_W'($urandom_range(0, 255));
      attr_plan[3] = tcw_pkg::ATTR_W'($urandom_range(0, 255));
      attr_plan[4] = tcw_pkg::RESET_ATTR;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed part, under the reset attribute; the block's clearing pass
      // after reset simply shows up as a long wait on the first beat
      read_at('0);                      // untouched cell reads blank
      read_at(tcw_pkg::READ_ADDR_W'(tcw_pkg::CELL_COUNT - 1));
      put_byte(8'h00);                  // character code extremes
      put_byte(8'hff);
      put_byte(8'h41);
      put_byte(tcw_pkg::CH_BACKSPACE);  // steps back and blanks
      read_at(tcw_pkg::READ_ADDR_W'(2));
      read_at(tcw_pkg::READ_ADDR_W'(1));
      put_byte(tcw_pkg::CH_TAB);        // column 2 to 4
      put_byte(tcw_pkg::CH_NEWLINE);
      put_byte(tcw_pkg::CH_BACKSPACE);  // at the left margin: no effect
      put_byte(8'h7f);
      read_at(tcw_pkg::READ_ADDR_W'(tcw_pkg::COLUMNS));
      read_at(tcw_pkg::READ_ADDR_W'(tcw_pkg::CELL_COUNT));   // just out of range
      read_at(READ_ADDR_TOP);           // far out of range
      send_item(OP_SPARE, 8'hff, READ_ADDR_TOP);
      send_item(tcw_pkg::OP_CLEAR, 8'h00, '0);
      read_at(tcw_pkg::READ_ADDR_W'(tcw_pkg::COLUMNS));
      read_at('0);

      for (int p = 0; p < PHASES; p++) begin
         // attribute only changes with nothing in flight
         wait_drained();
         write_attribute(attr_plan[p]);
         if (p == 0) begin
            // tabs run off the line end, then newlines run off the bottom
            repeat (20) put_byte(tcw_pkg::CH_TAB);
            repeat (tcw_pkg::ROWS + 1) put_byte(tcw_pkg::CH_NEWLINE);
            put_byte(8'h5a);
            read_at(tcw_pkg::READ_ADDR_W'(tcw_pkg::SHIFT_CELLS));
         end
         while (items_sent < 20 + (p + 1) * PHASE_ITEMS) begin
            run_burst(pick_burst());
         end
      end

      wait_drained();
      // stray beats would show up in the checker during this tail
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
